/* rtl/core/tfn_pkg.sv */
// shared types and widths for the triangle face normal block
// no dependencies
package tfn_pkg;

  localparam int unsigned CW = 16;  // vertex coordinate width, q8.8
  localparam int unsigned EW = 17;  // edge vector width
  localparam int unsigned NW = 35;  // cross product width, signed
  localparam int unsigned MW = 34;  // cross product magnitude width
  localparam int unsigned HW = 17;  // half of a magnitude for split squaring
  localparam int unsigned PW = 34;  // partial product width
  localparam int unsigned LW = 68;  // squared length width
  localparam int unsigned RW = 96;  // component square scaled by 2^30
  localparam int unsigned SW = 101; // search accumulator width, signed
  localparam int unsigned QW = 15;  // rounded magnitude width
  localparam int unsigned OW = 16;  // output component width, q1.14
  localparam int unsigned NB = 15;  // result bits resolved, one per stage
  localparam int unsigned FD = 4;   // queue depth
  localparam int unsigned FAW = 2;  // queue address width

  // one classified triangle handed from front to back
  typedef struct packed {
    logic            degen;
    logic [2:0]      neg;
    logic [2:0][MW-1:0] mag;
  } item_t;

endpackage

/* rtl/core/tfn_front.sv */
// front part: takes vertices, forms edges and cross product, classifies sign and degeneracy
// depends on tfn_pkg
module tfn_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [9*16-1:0]      in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tfn_pkg::item_t       out_item_o
);
  import tfn_pkg::*;

  logic                   en;
  logic                   v1_q, v2_q;
  logic signed [EW-1:0]   e1_q [3];
  logic signed [EW-1:0]   e2_q [3];
  logic signed [CW-1:0]   crd [9];
  logic signed [NW-1:0]   n [3];
  logic signed [NW-1:0]   n_abs [3];
  item_t                  item_d, item_q;

  assign en         = !v2_q || out_ready_i;
  assign in_ready_o = en;

  for (genvar i = 0; i < 9; i++) begin : g_crd
    assign crd[i] = $signed(in_data_i[i*CW +: CW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  // edges b-a and c-a
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= EW'(crd[3+i]) - EW'(crd[i]);
        e2_q[i] <= EW'(crd[6+i]) - EW'(crd[i]);
      end
    end
  end

  assign n[0] = NW'(e1_q[1] * e2_q[2]) - NW'(e1_q[2] * e2_q[1]);
  assign n[1] = NW'(e1_q[2] * e2_q[0]) - NW'(e1_q[0] * e2_q[2]);
  assign n[2] = NW'(e1_q[0] * e2_q[1]) - NW'(e1_q[1] * e2_q[0]);

  always_comb begin
    item_d.degen = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
    for (int i = 0; i < 3; i++) begin
      n_abs[i]       = n[i][NW-1] ? -n[i] : n[i];
      item_d.neg[i]  = n[i][NW-1];
      item_d.mag[i]  = n_abs[i][MW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) item_q <= item_d;
  end

  assign out_valid_o = v2_q;
  assign out_item_o  = item_q;

endmodule

/* rtl/core/tfn_fifo.sv */
// short queue between front and back parts
// depends on tfn_pkg
module tfn_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tfn_pkg::item_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tfn_pkg::item_t  out_item_o
);
  import tfn_pkg::*;

  item_t          mem_q [FD];
  logic [FAW-1:0] wr_q, rd_q;
  logic [FAW:0]   cnt_q;
  logic           push, pop;

  assign in_ready_o  = (cnt_q != (FAW+1)'(FD));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FAW+1)'(push) - (FAW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

endmodule

/* rtl/core/tfn_back.sv */
// back part: squared length, then one rounded result bit per stage for each component
// depends on tfn_pkg
module tfn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tfn_pkg::item_t    in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3*16-1:0]   out_data_o,
  output logic              out_degen_o
);
  import tfn_pkg::*;

  logic en;
  logic v0_q, v1_q;
  logic [NB:0] iv_q;

  // split squaring, stage 0
  logic [PW-1:0] hh_q [3], hl_q [3], ll_q [3];
  logic [2:0]    neg0_q, neg1_q;
  logic          dg0_q, dg1_q;
  // square assembly, stage 1
  logic [LW-1:0] sq_q [3];

  // search stages: index 0 is the setup, index j+1 resolves bit NB-1-j
  logic signed [SW-1:0] p_q [NB+1][3];
  logic signed [SW-1:0] s_q [NB+1][3];
  logic [RW-1:0]        r_q [NB+1][3];
  logic [QW-1:0]        q_q [NB+1][3];
  logic [LW-1:0]        l_q [NB+1];
  logic [2:0]           neg_q [NB+1];
  logic                 dg_q [NB+1];

  logic [LW-1:0] len2;

  assign en         = !iv_q[NB] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      iv_q <= '0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      iv_q <= {iv_q[NB-1:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= in_item_i.mag[i][MW-1:HW] * in_item_i.mag[i][MW-1:HW];
        hl_q[i] <= in_item_i.mag[i][MW-1:HW] * in_item_i.mag[i][HW-1:0];
        ll_q[i] <= in_item_i.mag[i][HW-1:0]  * in_item_i.mag[i][HW-1:0];
        sq_q[i] <= (LW'(hh_q[i]) << (2*HW)) + (LW'(hl_q[i]) << (HW+1)) + LW'(ll_q[i]);
      end
      neg0_q <= in_item_i.neg;
      dg0_q  <= in_item_i.degen;
      neg1_q <= neg0_q;
      dg1_q  <= dg0_q;
    end
  end

  assign len2 = sq_q[0] + sq_q[1] + sq_q[2];

  // setup: q = 0, so t = -1, p = t*L and s = t*t*L
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[0][i] <= -$signed({{(SW-LW){1'b0}}, len2});
        s_q[0][i] <= $signed({{(SW-LW){1'b0}}, len2});
        r_q[0][i] <= {sq_q[i][RW-31:0], 30'd0};
        q_q[0][i] <= '0;
      end
      l_q[0]   <= len2;
      neg_q[0] <= neg1_q;
      dg_q[0]  <= dg1_q;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_step
    localparam int unsigned K = NB - 1 - j;
    logic signed [SW-1:0] lx;
    logic signed [SW-1:0] p_t [3];
    logic signed [SW-1:0] s_t [3];
    logic                 ok [3];

    assign lx = $signed({{(SW-LW){1'b0}}, l_q[j]});

    // t grows by 2^(K+1): t'L = tL + 2^(K+1)L, t'^2 L = t^2 L + 2^(K+2) tL + 2^(2K+2) L
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign p_t[i] = p_q[j][i] + (lx <<< (K+1));
      assign s_t[i] = s_q[j][i] + (p_q[j][i] <<< (K+2)) + (lx <<< (2*K+2));
      assign ok[i]  = s_t[i] <= $signed({{(SW-RW){1'b0}}, r_q[j][i]});
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          p_q[j+1][i] <= ok[i] ? p_t[i] : p_q[j][i];
          s_q[j+1][i] <= ok[i] ? s_t[i] : s_q[j][i];
          q_q[j+1][i] <= q_q[j][i] | (QW'(ok[i]) << K);
          r_q[j+1][i] <= r_q[j][i];
        end
        l_q[j+1]   <= l_q[j];
        neg_q[j+1] <= neg_q[j];
        dg_q[j+1]  <= dg_q[j];
      end
    end
  end

  // apply sign; a degenerate item reads as a zero vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dg_q[NB]) begin
        out_data_o[i*OW +: OW] = '0;
      end else if (neg_q[NB][i]) begin
        out_data_o[i*OW +: OW] = -OW'(q_q[NB][i]);
      end else begin
        out_data_o[i*OW +: OW] = OW'(q_q[NB][i]);
      end
    end
  end

  assign out_valid_o = iv_q[NB];
  assign out_degen_o = dg_q[NB];

endmodule

/* rtl/core/triangle_face_normal.sv */
// top level of the triangle face normal block
// depends on tfn_pkg, tfn_front, tfn_fifo, tfn_back
//
// usage
//   slave stream carries one triangle per transfer: nine signed q8.8
//   coordinates a, b, c packed in tdata
//   master stream returns one transfer per triangle: the unit normal of
//   (b-a) x (c-a) in signed q1.14, rounded to nearest, in tdata, and a
//   degenerate flag in tuser (set when the cross product is zero, normal
//   then zero)
//   throughput is one triangle per cycle while neither pipeline stalls; the path runs
//   through two front stages, the queue's registered storage, two squaring stages,
//   one setup stage and fifteen search stages, one result bit each
//   the front and back pipelines stall independently, the four-entry queue
//   between them absorbing the difference
//   when the receiver holds tready low the result stays on the master port
//   and the back pipeline freezes; the front keeps taking triangles until
//   the queue fills
//   reset clears all valid flags and the queue pointers and count; data registers are not reset
module triangle_face_normal (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up, 16 bits each
  input  logic [143:0]  s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // normal_x, normal_y, normal_z from bit 0 up, 16 bits each
  output logic [47:0]   m_axis_tdata_o,
  // degenerate
  output logic          m_axis_tuser_o
);
  import tfn_pkg::*;

  // front to queue
  logic  fr_valid, fr_ready;
  item_t fr_item;
  // queue to back
  logic  bk_valid, bk_ready;
  item_t bk_item;

  tfn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  tfn_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_item_i   (fr_item),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_item_o  (bk_item)
  );

  // the back part drains the queue whenever its own pipeline can advance
  tfn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_item_i   (bk_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_degen_o (m_axis_tuser_o)
  );

endmodule

/* rtl/core/tfn_checker.sv */
// port-level checks for the triangle face normal block, bound to the top level
// depends on triangle_face_normal ports only
module tfn_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [47:0]  m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // degenerate triangle gives a zero normal
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 48'd0)
    else $error("degenerate result not zero");

  // a proper triangle never gives an all-zero normal
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o != 48'd0)
    else $error("zero normal without degenerate flag");

  // x component stays within plus or minus one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(m_axis_tdata_o[15:0]) <= 16'sd16384) &&
      ($signed(m_axis_tdata_o[15:0]) >= -16'sd16384))
    else $error("normal x out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
